// ----- design/ssra_pkg.sv -----
// Shared types and constants of the swap slot reference count allocator.
// No dependencies; the interfaces, the top level and the sequencer import this package.
package ssra_pkg;

  localparam int SLOTS_DEF       = 1024;
  localparam int COUNT_WIDTH_DEF = 8;

  localparam int OPCODE_W   = 3;
  localparam int SLOT_W     = 10;
  localparam int BLOCK_W    = 32;
  localparam int COUNT_W    = 11;
  localparam int STATUS_W   = 2;
  localparam int MAP_WORD_W = 32;
  localparam int MAP_BIT_W  = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC      = 3'd0,
    OP_SHARE      = 3'd1,
    OP_RELEASE    = 3'd2,
    OP_DEC_GET    = 3'd3,
    OP_COUNT_FREE = 3'd4
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_e;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [SLOT_W-1:0]   slot_index;
  } item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [BLOCK_W-1:0]  block_address;
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;
  } result_t;

  typedef struct packed {
    logic in_valid;
    logic alloc_req;
    logic none_free;
    logic word_found;
    logic out_free;
    logic clear_done;
  } seq_status_t;

  typedef struct packed {
    logic in_ready;
    logic clearing;
    logic exec_done;
    logic scan_next;
    logic scan_commit;
  } seq_ctrl_t;

endpackage

// ----- design/ssra_if.sv -----
// Handshake channels of the allocator: request items, results and swap base writes.
// Depends on ssra_pkg for the payload types.
interface ssra_item_if import ssra_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ssra_result_if import ssra_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ssra_cfg_if import ssra_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BLOCK_W-1:0] swap_base;
  modport source (output valid, output swap_base, input ready);
  modport sink (input valid, input swap_base, output ready);
endinterface

// ----- design/swap_slot_refcount_allocator_top.sv -----
// Swap slot allocator top level: count store, free map, datapath and result register.
// Depends on ssra_pkg, ssra_if, ssra_ram and ssra_seq.
//
// Reference counts live in a one-read one-write RAM of SLOTS entries; a second RAM holds a
// bitmap of free slots, 32 per word. After reset the block runs a clearing pass over all
// SLOTS entries (1024 by default) with in_i.ready low; swap base writes are taken throughout.
// For share, release, decrement-and-get, count-free and unused opcodes each item is first
// read from the RAMs, then modified, written back and loaded into the result register once
// that is free. Allocate reads the free map one word at a time, from the lowest word that
// may hold a free slot up to the word that holds the first free one; allocate with no free
// slot is handled like the other opcodes. A finished result waits in the output register
// while the next item is accepted and read.
module swap_slot_refcount_allocator_top import ssra_pkg::*; #(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssra_cfg_if.sink    cfg_i,
  ssra_item_if.sink   in_i,
  ssra_result_if.source out_o
);

  localparam int SW        = $clog2(SLOTS);
  localparam int FT_W      = $clog2(SLOTS + 1);
  localparam int WORDS     = (SLOTS + MAP_WORD_W - 1) / MAP_WORD_W;
  localparam int WAW       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int MAP_DEPTH = 1 << WAW;
  localparam int LAST_WORD = WORDS - 1;
  localparam int LAST_BITS = SLOTS - LAST_WORD * MAP_WORD_W;
  localparam logic [MAP_WORD_W-1:0] LAST_MASK = (LAST_BITS >= MAP_WORD_W) ? '1 :
      MAP_WORD_W'((64'd1 << LAST_BITS) - 64'd1);
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  function automatic logic [SW-1:0] reduce_idx(logic [SLOT_W-1:0] v);
    logic [SLOT_W:0] r;
    r = {1'b0, v};
    for (int k = SLOT_W - 1; k >= 0; k--) begin
      if ((SLOTS << k) < (1 << SLOT_W)) begin
        if (r >= (SLOT_W + 1)'(SLOTS << k)) r = r - (SLOT_W + 1)'(SLOTS << k);
      end
    end
    return SW'(r);
  endfunction

  function automatic logic [MAP_WORD_W-1:0] map_init(logic [WAW-1:0] w);
    logic [MAP_WORD_W-1:0] m;
    if (w < WAW'(LAST_WORD)) m = '1;
    else if (w == WAW'(LAST_WORD)) m = LAST_MASK;
    else m = '0;
    return m;
  endfunction

  seq_status_t seq_status;
  seq_ctrl_t   ctrl;

  logic [BLOCK_W-1:0]  base_q;
  logic [OPCODE_W-1:0] op_q;
  logic [SW-1:0]       idx_q;
  logic [FT_W-1:0]     free_q, free_d;
  logic [WAW-1:0]      hint_q, hint_d;
  logic [SW-1:0]       clr_q;
  logic                out_valid_q;
  result_t             out_q, res;
  logic                load_out;

  logic                  in_fire;
  logic [SW-1:0]         in_idx;
  logic [WAW-1:0]        in_word, idx_word, clr_word;
  logic [MAP_BIT_W-1:0]  idx_bit, first_pos;
  logic [MAP_WORD_W-1:0] idx_mask, pos_mask;
  logic [SW-1:0]         found_slot;

  logic                   cnt_we, cnt_re;
  logic [SW-1:0]          cnt_waddr, cnt_raddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rd;
  logic                   map_we, map_re;
  logic [WAW-1:0]         map_waddr, map_raddr;
  logic [MAP_WORD_W-1:0]  map_wdata, map_rd;

  ssra_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (seq_status),
    .ctrl_o   (ctrl)
  );

  ssra_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(SLOTS)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rd)
  );

  ssra_ram #(.WIDTH(MAP_WORD_W), .DEPTH(MAP_DEPTH)) u_free_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rd)
  );

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = ctrl.in_ready;
  assign in_fire     = in_i.valid && ctrl.in_ready;

  assign in_idx     = reduce_idx(in_i.payload.slot_index);
  assign in_word    = WAW'(in_idx >> MAP_BIT_W);
  assign idx_word   = WAW'(idx_q >> MAP_BIT_W);
  assign idx_bit    = MAP_BIT_W'(idx_q);
  assign idx_mask   = MAP_WORD_W'(1) << idx_bit;
  assign clr_word   = WAW'(clr_q >> MAP_BIT_W);
  assign pos_mask   = MAP_WORD_W'(1) << first_pos;
  assign found_slot = SW'({hint_q, first_pos});

  always_comb begin
    first_pos = '0;
    for (int i = MAP_WORD_W - 1; i >= 0; i--) begin
      if (map_rd[i]) first_pos = MAP_BIT_W'(i);
    end
  end

  always_comb begin
    seq_status            = '0;
    seq_status.in_valid   = in_i.valid;
    seq_status.alloc_req  = (in_i.payload.opcode == OP_ALLOC);
    seq_status.none_free  = (free_q == '0);
    seq_status.word_found = (map_rd != '0);
    seq_status.out_free   = !out_valid_q || out_o.ready;
    seq_status.clear_done = (clr_q == SW'(SLOTS - 1));
  end

  // read side
  assign cnt_re    = in_fire;
  assign cnt_raddr = in_idx;
  assign map_re    = in_fire || ctrl.scan_next;

  always_comb begin
    if (ctrl.scan_next) map_raddr = WAW'(hint_q + 1'b1);
    else if (in_i.payload.opcode == OP_ALLOC) map_raddr = hint_q;
    else map_raddr = in_word;
  end

  // modify and write back
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = idx_q;
    cnt_wdata = '0;
    map_we    = 1'b0;
    map_waddr = idx_word;
    map_wdata = map_rd;
    free_d    = free_q;
    hint_d    = hint_q;
    res       = '0;
    load_out  = 1'b0;

    if (ctrl.clearing) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_q;
      cnt_wdata = '0;
      map_we    = 1'b1;
      map_waddr = clr_word;
      map_wdata = map_init(clr_word);
    end

    if (ctrl.scan_next) begin
      hint_d = WAW'(hint_q + 1'b1);
    end

    if (ctrl.scan_commit) begin
      load_out          = 1'b1;
      cnt_we            = 1'b1;
      cnt_waddr         = found_slot;
      cnt_wdata         = COUNT_WIDTH'(1);
      map_we            = 1'b1;
      map_waddr         = hint_q;
      map_wdata         = map_rd & ~pos_mask;
      free_d            = free_q - 1'b1;
      res.slot          = SLOT_W'(found_slot);
      res.block_address = base_q + BLOCK_W'(found_slot);
      res.count         = COUNT_W'(1);
      res.status        = ST_OK;
    end

    if (ctrl.exec_done) begin
      load_out          = 1'b1;
      res.slot          = SLOT_W'(idx_q);
      res.block_address = base_q + BLOCK_W'(idx_q);
      unique case (opcode_e'(op_q)) inside
        OP_SHARE: begin
          if (cnt_rd == CMAX) begin
            res.count  = COUNT_W'(CMAX);
            res.status = ST_OVERFLOW;
          end else begin
            cnt_we     = 1'b1;
            cnt_wdata  = cnt_rd + 1'b1;
            res.count  = COUNT_W'(cnt_wdata);
            res.status = ST_OK;
            if (cnt_rd == '0) begin
              map_we    = 1'b1;
              map_wdata = map_rd & ~idx_mask;
              free_d    = free_q - 1'b1;
            end
          end
        end
        OP_RELEASE, OP_DEC_GET: begin
          if (cnt_rd == '0) begin
            res.count  = '0;
            res.status = ST_UNDERFLOW;
          end else begin
            cnt_we     = 1'b1;
            cnt_wdata  = cnt_rd - 1'b1;
            res.count  = COUNT_W'(cnt_wdata);
            res.status = ST_OK;
            if (cnt_wdata == '0) begin
              map_we    = 1'b1;
              map_wdata = map_rd | idx_mask;
              free_d    = free_q + 1'b1;
              if (idx_word < hint_q) hint_d = idx_word;
            end
          end
        end
        OP_COUNT_FREE: begin
          res.slot          = '0;
          res.block_address = '0;
          res.count         = COUNT_W'(free_q);
          res.status        = ST_OK;
        end
        OP_ALLOC: begin
          res.slot          = '0;
          res.block_address = '0;
          res.status        = ST_NO_FREE;
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      free_q      <= FT_W'(SLOTS);
      hint_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) base_q <= cfg_i.swap_base;
      free_q <= free_d;
      hint_q <= hint_d;
      if (ctrl.clearing) clr_q <= SW'(clr_q + 1'b1);
      if (load_out) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= in_i.payload.opcode;
      idx_q <= in_idx;
    end
    if (load_out) out_q <= res;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  a_scan_has_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.scan_next || ctrl.scan_commit) |-> free_q != '0)
    else $error("free map scan running with no free slot");

  a_scan_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.scan_next |-> hint_q < WAW'(LAST_WORD))
    else $error("free map scan stepped past the last word");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || out_o.ready))
    else $error("result register loaded over a pending beat");

  a_alloc_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.scan_commit |=> free_q == FT_W'($past(free_q) - 1'b1))
    else $error("free total not decremented on allocate");

  a_free_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= FT_W'(SLOTS))
    else $error("free total exceeds slot count");

endmodule

// ----- design/ssra_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
// No package dependencies; used for the count store and the free map.
module ssra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/ssra_seq.sv -----
// Sequencer of the allocator: clear sweep, accept, execute and free map scan.
// Depends on ssra_pkg for the state, status and control types.
module ssra_seq import ssra_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  seq_status_t status_i,
  output seq_ctrl_t   ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (status_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (status_i.in_valid) begin
          if (status_i.alloc_req && !status_i.none_free) state_d = S_SCAN;
          else state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      S_SCAN: begin
        if (status_i.word_found && status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    ctrl_o             = '0;
    ctrl_o.in_ready    = (state_q == S_IDLE);
    ctrl_o.clearing    = (state_q == S_CLEAR);
    ctrl_o.exec_done   = (state_q == S_EXEC) && status_i.out_free;
    ctrl_o.scan_next   = (state_q == S_SCAN) && !status_i.word_found;
    ctrl_o.scan_commit = (state_q == S_SCAN) && status_i.word_found && status_i.out_free;
  end

endmodule
